// File: src/tws_pkg.sv
`timescale 1ns / 1ps
package tws_pkg;

  localparam int MAX_SIDE    = 256;
  localparam int SIDE_W      = $clog2(MAX_SIDE) + 1;
  localparam int POS_W       = $clog2(MAX_SIDE);
  localparam int ADDR_W      = 2 * POS_W;
  localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int TEXEL_BITS  = 16;
  localparam int FRAC_W      = 16;
  localparam int INDEX_W     = 16;
  localparam int VALUE_W     = 16;
  localparam int COORD_W     = 24;
  localparam int RESULT_W    = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 9;

  localparam int CMD_Q_DEPTH = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_Q_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_Q_DEPTH + 1);
  localparam int RES_Q_DEPTH = 16;
  localparam int RES_PTR_W   = $clog2(RES_Q_DEPTH);
  localparam int RES_CNT_W   = $clog2(RES_Q_DEPTH + 1);

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

  typedef struct packed {
    logic                  is_sample;
    logic [INDEX_W-1:0]    index;
    logic [TEXEL_BITS-1:0] value;
    logic [FRAC_W-1:0]     frac_u;
    logic [FRAC_W-1:0]     frac_v;
  } cmd_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (s == '0) r = SIDE_W'(1);
    else if (s > CFG_DATA_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    else r = SIDE_W'(s);
    return r;
  endfunction

endpackage

// File: src/bilinear_wrap_texture_sampler.sv
`timescale 1ns / 1ps
// channel  | handshake         | beat
// in       | in_push / in_full | mode, texel_index, texel_value, coord_u, coord_v
// out      | out_pop / out_empty | sample_value
// cfg      | cfg_we            | cfg_index, cfg_data
// One item per cycle sustained while in_full is low and result slots are free; a sample reaches
// out through the command queue, the seven-stage back pipeline (registered texel memory reads) and the result queue.
// Reset clears queues and pipeline valids and sets both sizes to 256; texels are
// not cleared. The back pipeline never stalls: samples enter it only when a result
// slot is free, so out_pop held low backs up into the command queue and then in_full.
module bilinear_wrap_texture_sampler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_mode,
  input  logic [tws_pkg::INDEX_W-1:0]     in_texel_index,
  input  logic [tws_pkg::VALUE_W-1:0]     in_texel_value,
  input  logic [tws_pkg::COORD_W-1:0]     in_coord_u,
  input  logic [tws_pkg::COORD_W-1:0]     in_coord_v,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [tws_pkg::RESULT_W-1:0]    out_sample_value,
  input  logic                            cfg_we,
  input  logic [tws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tws_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tws_pkg::*;

  logic [CFG_DATA_W-1:0] tex_width_r, tex_height_r;
  logic [SIDE_W-1:0]     tex_w, tex_h;
  logic                  deq_valid, deq_ready, issue, credit_ok;
  cmd_t                  deq_cmd;
  logic                  res_vld;
  logic [RESULT_W-1:0]   res_value;
  logic [RES_CNT_W-1:0]  res_cnt;
  logic [RES_CNT_W-1:0]  inflight_r, inflight_nxt;
  logic [RES_CNT_W:0]    committed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= SIDE_RESET;
      tex_height_r <= SIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_data;
        REG_TEX_HEIGHT: tex_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tex_w = clamp_side(tex_width_r);
  assign tex_h = clamp_side(tex_height_r);

  tws_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_texel_index (in_texel_index),
    .in_texel_value (in_texel_value),
    .in_coord_u     (in_coord_u),
    .in_coord_v     (in_coord_v),
    .deq_valid      (deq_valid),
    .deq_ready      (deq_ready),
    .deq_cmd        (deq_cmd)
  );

  assign committed = (RES_CNT_W + 1)'(inflight_r) + (RES_CNT_W + 1)'(res_cnt);
  assign credit_ok = committed < (RES_CNT_W + 1)'(RES_Q_DEPTH);
  assign deq_ready = !deq_cmd.is_sample || credit_ok;
  assign issue     = deq_valid && deq_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if ((issue && deq_cmd.is_sample) && !res_vld) inflight_nxt = inflight_r + 1'b1;
    else if (!(issue && deq_cmd.is_sample) && res_vld) inflight_nxt = inflight_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else        inflight_r <= inflight_nxt;
  end

  tws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .cmd       (deq_cmd),
    .tex_w     (tex_w),
    .tex_h     (tex_h),
    .res_vld   (res_vld),
    .res_value (res_value)
  );

  tws_res_q u_res_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_vld),
    .push_value (res_value),
    .empty      (out_empty),
    .pop        (out_pop),
    .head_value (out_sample_value),
    .count      (res_cnt)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    committed <= (RES_CNT_W + 1)'(RES_Q_DEPTH))
    else $error("result slots overcommitted");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (res_cnt < RES_CNT_W'(RES_Q_DEPTH)) || (out_pop && !out_empty))
    else $error("result pushed into full queue");

  a_result_owed: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> inflight_r != '0)
    else $error("result without an in-flight sample");

endmodule

// File: src/tws_front.sv
`timescale 1ns / 1ps
module tws_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_mode,
  input  logic [tws_pkg::INDEX_W-1:0]   in_texel_index,
  input  logic [tws_pkg::VALUE_W-1:0]   in_texel_value,
  input  logic [tws_pkg::COORD_W-1:0]   in_coord_u,
  input  logic [tws_pkg::COORD_W-1:0]   in_coord_v,
  output logic                          deq_valid,
  input  logic                          deq_ready,
  output tws_pkg::cmd_t                 deq_cmd
);
  import tws_pkg::*;

  cmd_t                 q_r [CMD_Q_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t                 cmd;
  logic                 push, pop;

  // integer part of a coordinate drops out of the wrap; only the fraction is kept
  always_comb begin
    cmd.is_sample = (in_mode == MODE_SAMPLE);
    cmd.index     = in_texel_index;
    cmd.value     = in_texel_value[TEXEL_BITS-1:0];
    cmd.frac_u    = in_coord_u[FRAC_W-1:0];
    cmd.frac_v    = in_coord_v[FRAC_W-1:0];
  end

  assign in_full   = (cnt_r == CMD_CNT_W'(CMD_Q_DEPTH));
  assign deq_valid = (cnt_r != '0);
  assign deq_cmd   = q_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cmd;
  end

endmodule

// File: src/tws_back.sv
`timescale 1ns / 1ps
module tws_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           issue,
  input  tws_pkg::cmd_t                  cmd,
  input  logic [tws_pkg::SIDE_W-1:0]     tex_w,
  input  logic [tws_pkg::SIDE_W-1:0]     tex_h,
  output logic                           res_vld,
  output logic [tws_pkg::RESULT_W-1:0]   res_value
);
  import tws_pkg::*;

  localparam int PROD_W  = FRAC_W + SIDE_W;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int BPROD_W = TEXEL_BITS + WGT_W;
  localparam logic [WGT_W-1:0] ONE_Q = WGT_W'(1) << FRAC_W;
  localparam logic [BPROD_W-1:0] HALF_Q = BPROD_W'(1) << (FRAC_W - 1);

  logic [TEXEL_BITS-1:0] mem_a [STORE_DEPTH];
  logic [TEXEL_BITS-1:0] mem_b [STORE_DEPTH];

  // stage 1: scale fractions by size
  logic                  s1_vld_r, s1_smp_r;
  logic [INDEX_W-1:0]    s1_idx_r;
  logic [TEXEL_BITS-1:0] s1_val_r;
  logic [PROD_W-1:0]     s1_pu_r, s1_pv_r;
  // stage 2: wrapped positions, row bases
  logic                  s2_vld_r, s2_smp_r;
  logic [INDEX_W-1:0]    s2_idx_r;
  logic [TEXEL_BITS-1:0] s2_val_r;
  logic [POS_W-1:0]      s2_x0_r, s2_x1_r;
  logic [FRAC_W-1:0]     s2_fx_r, s2_fy_r;
  logic [ADDR_W-1:0]     s2_row0_r, s2_row1_r;
  // stage 3: memory read data
  logic                  s3_vld_r;
  logic [FRAC_W-1:0]     s3_fx_r, s3_fy_r;
  logic [TEXEL_BITS-1:0] c00_r, c10_r, c01_r, c11_r;
  // stage 4: horizontal products
  logic                  s4_vld_r;
  logic [FRAC_W-1:0]     s4_fy_r;
  logic [BPROD_W-1:0]    p00_r, p10_r, p01_r, p11_r;
  // stage 5: horizontal blends
  logic                  s5_vld_r;
  logic [FRAC_W-1:0]     s5_fy_r;
  logic [TEXEL_BITS-1:0] c0_r, c1_r;
  // stage 6: vertical products
  logic                  s6_vld_r;
  logic [BPROD_W-1:0]    q0_r, q1_r;
  // stage 7: result
  logic                  s7_vld_r;
  logic [TEXEL_BITS-1:0] s7_val_r;

  logic [POS_W-1:0]  x0, y0, x1, y1;
  logic [SIDE_W-1:0] x0p1, y0p1;
  logic [ADDR_W-1:0] a00, a10, a01, a11;
  logic [BPROD_W-1:0] sum0, sum1, sumv;

  // position = floor(frac * size) is already below size
  always_comb begin
    x0   = s1_pu_r[FRAC_W +: POS_W];
    y0   = s1_pv_r[FRAC_W +: POS_W];
    x0p1 = SIDE_W'(x0) + 1'b1;
    y0p1 = SIDE_W'(y0) + 1'b1;
    x1   = (x0p1 == tex_w) ? '0 : x0p1[POS_W-1:0];
    y1   = (y0p1 == tex_h) ? '0 : y0p1[POS_W-1:0];
  end

  always_comb begin
    a00 = s2_row0_r + ADDR_W'(s2_x0_r);
    a10 = s2_row0_r + ADDR_W'(s2_x1_r);
    a01 = s2_row1_r + ADDR_W'(s2_x0_r);
    a11 = s2_row1_r + ADDR_W'(s2_x1_r);
  end

  always_comb begin
    sum0 = p00_r + p10_r + HALF_Q;
    sum1 = p01_r + p11_r + HALF_Q;
    sumv = q0_r + q1_r + HALF_Q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_smp_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_smp_r <= cmd.is_sample;
    s1_idx_r <= cmd.index;
    s1_val_r <= cmd.value;
    s1_pu_r  <= PROD_W'(cmd.frac_u) * PROD_W'(tex_w);
    s1_pv_r  <= PROD_W'(cmd.frac_v) * PROD_W'(tex_h);

    s2_smp_r  <= s1_smp_r;
    s2_idx_r  <= s1_idx_r;
    s2_val_r  <= s1_val_r;
    s2_x0_r   <= x0;
    s2_x1_r   <= x1;
    s2_fx_r   <= s1_pu_r[FRAC_W-1:0];
    s2_fy_r   <= s1_pv_r[FRAC_W-1:0];
    s2_row0_r <= ADDR_W'(SIDE_W'(y0) * tex_w);
    s2_row1_r <= ADDR_W'(SIDE_W'(y1) * tex_w);

    s3_fx_r <= s2_fx_r;
    s3_fy_r <= s2_fy_r;

    s4_fy_r <= s3_fy_r;
    p00_r   <= BPROD_W'(c00_r) * BPROD_W'(ONE_Q - WGT_W'(s3_fx_r));
    p10_r   <= BPROD_W'(c10_r) * BPROD_W'(s3_fx_r);
    p01_r   <= BPROD_W'(c01_r) * BPROD_W'(ONE_Q - WGT_W'(s3_fx_r));
    p11_r   <= BPROD_W'(c11_r) * BPROD_W'(s3_fx_r);

    s5_fy_r <= s4_fy_r;
    c0_r    <= sum0[FRAC_W +: TEXEL_BITS];
    c1_r    <= sum1[FRAC_W +: TEXEL_BITS];

    q0_r <= BPROD_W'(c0_r) * BPROD_W'(ONE_Q - WGT_W'(s5_fy_r));
    q1_r <= BPROD_W'(c1_r) * BPROD_W'(s5_fy_r);

    s7_val_r <= sumv[FRAC_W +: TEXEL_BITS];
  end

  // two copies, each with two read ports; writes land in both
  always_ff @(posedge clk) begin
    if (s2_vld_r && !s2_smp_r) mem_a[s2_idx_r] <= s2_val_r;
    c00_r <= mem_a[a00];
    c10_r <= mem_a[a10];
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r && !s2_smp_r) mem_b[s2_idx_r] <= s2_val_r;
    c01_r <= mem_b[a01];
    c11_r <= mem_b[a11];
  end

  assign res_vld   = s7_vld_r;
  assign res_value = RESULT_W'(s7_val_r);

endmodule

// File: src/tws_res_q.sv
`timescale 1ns / 1ps
module tws_res_q (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [tws_pkg::RESULT_W-1:0]  push_value,
  output logic                          empty,
  input  logic                          pop,
  output logic [tws_pkg::RESULT_W-1:0]  head_value,
  output logic [tws_pkg::RES_CNT_W-1:0] count
);
  import tws_pkg::*;

  logic [RESULT_W-1:0]  q_r [RES_Q_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_pop;

  assign empty      = (cnt_r == '0);
  assign head_value = q_r[rd_ptr_r];
  assign count      = cnt_r;
  assign do_pop     = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push)   wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_value;
  end

endmodule
